// ===== hw/rtl/ibwt_pkg.sv =====
// Package for the inverse BWT block: status codes and action codes.
// No dependencies; used by the RAM-based top level.
package ibwt_pkg;
  localparam int unsigned SYMBOLS = 256;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
  localparam logic [1:0] STATUS_NOT_READY = 2'd3;
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_PULL = 1'b1;
endpackage

// ===== hw/rtl/ibwt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ibwt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/inverse_bwt_block.sv =====
// Top level of the inverse BWT block: load, histogram, rank, walk, pull.
// Depends on ibwt_pkg and ibwt_ram.
//
// The block handles one transaction at a time, and each result must be taken
// before the next transaction is accepted. A load transaction passes through
// the accept state, a read and a write of the byte's histogram count, and the
// result state. A pull passes through accept, the registered read of the
// restored byte, and the result. A pull with nothing ready, and a load that
// finds the store full, go from accept straight to the result. The histogram
// is cleared by a sweep over all 256 entries after reset, after a discarded
// block and after the final byte of a block has been pulled. A load presented
// while a finished block is held starts the same sweep first, and tready stays
// low until it ends. After the last load of a good block, the block turns
// counts into running starts (a read and a write per symbol), forms ranks (a
// coded-byte read, a count read, then a rank and count write per byte) and
// walks the chain (a read and a write per byte), all through one shared RAM
// read port per store, before the result of that last load is offered.
module inverse_bwt_block
  import ibwt_pkg::*;
#(
  parameter int unsigned BLOCK_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: byte_in [7:0], start row [19:8], zero [23:20]
  input  logic [23:0] s_axis_tdata,
  // tuser: action
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: byte_out [7:0], out_valid [8], status [10:9], zero [15:11]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int unsigned AW = $clog2(BLOCK_MAX);
  localparam int unsigned LW = $clog2(BLOCK_MAX + 1);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_CNT_RD = 11'b00000000100,
    ST_CNT_WR = 11'b00000001000,
    ST_PFX    = 11'b00000010000,
    ST_RNK_RD = 11'b00000100000,
    ST_RNK_WR = 11'b00001000000,
    ST_WLK_RD = 11'b00010000000,
    ST_WLK_WR = 11'b00100000000,
    ST_PULL   = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d, rp_q, rp_d, idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [8:0] sym_q, sym_d;
  logic [LW-1:0] run_q, run_d;
  logic ready_q, ready_d, over_q, over_d, last_q, last_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] stat_q, stat_d;
  logic ovalid_q, ovalid_d, olast_q, olast_d, obv_q, obv_d;
  logic pfx_ph_q, pfx_ph_d;

  // RAM ports.
  logic cs_we, ct_we, rk_we, rs_we;
  logic [AW-1:0] cs_wa, cs_ra, rk_wa, rk_ra, rs_wa, rs_ra;
  logic [7:0] cs_wd, cs_rd, rs_wd, rs_rd, ct_wa, ct_ra;
  logic [LW-1:0] ct_wd, ct_rd;
  logic [AW-1:0] rk_wd, rk_rd;

  ibwt_ram #(.Width(8), .Depth(BLOCK_MAX)) u_coded (
    .clk_i, .we_i(cs_we), .waddr_i(cs_wa), .wdata_i(cs_wd), .raddr_i(cs_ra), .rdata_o(cs_rd));
  ibwt_ram #(.Width(LW), .Depth(SYMBOLS)) u_count (
    .clk_i, .we_i(ct_we), .waddr_i(ct_wa), .wdata_i(ct_wd), .raddr_i(ct_ra), .rdata_o(ct_rd));
  ibwt_ram #(.Width(AW), .Depth(BLOCK_MAX)) u_rank (
    .clk_i, .we_i(rk_we), .waddr_i(rk_wa), .wdata_i(rk_wd), .raddr_i(rk_ra), .rdata_o(rk_rd));
  ibwt_ram #(.Width(8), .Depth(BLOCK_MAX)) u_rest (
    .clk_i, .we_i(rs_we), .waddr_i(rs_wa), .wdata_i(rs_wd), .raddr_i(rs_ra), .rdata_o(rs_rd));

  logic in_go;
  logic [LW-1:0] len_new;
  logic [AW-1:0] pi;
  // A load waits while a finished block is held, until the histogram is swept.
  assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid
                         && !(ready_q && s_axis_tuser == ACTION_LOAD);
  assign in_go = s_axis_tvalid && s_axis_tready;
  assign pi = AW'(s_axis_tdata[19:8]);

  // Sequencer: clear, load, count, prefix sum, rank, walk and pull.
  always_comb begin
    state_d = state_q; len_d = len_q; rp_d = rp_q; idx_d = idx_q; pos_d = pos_q;
    sym_d = sym_q; run_d = run_q; ready_d = ready_q; over_d = over_q; last_d = last_q;
    byte_d = byte_q; stat_d = stat_q; ovalid_d = ovalid_q; olast_d = olast_q;
    obv_d = obv_q; pfx_ph_d = pfx_ph_q; len_new = len_q;
    cs_we = 1'b0; ct_we = 1'b0; rk_we = 1'b0; rs_we = 1'b0;
    cs_wa = len_q[AW-1:0]; cs_wd = s_axis_tdata[7:0]; cs_ra = idx_q[AW-1:0];
    ct_wa = sym_q[7:0]; ct_wd = '0; ct_ra = byte_q;
    rk_wa = idx_q[AW-1:0]; rk_wd = '0; rk_ra = pos_q;
    rs_wa = idx_q[AW-1:0]; rs_wd = cs_rd; rs_ra = rp_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ct_we = 1'b1;
        sym_d = sym_q + 9'd1;
        if (sym_q == 9'd255) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_go) begin
          stat_d = STATUS_OK; ovalid_d = 1'b0; olast_d = 1'b0; obv_d = 1'b0;
          last_d = s_axis_tlast && (s_axis_tuser == ACTION_LOAD);
          if (s_axis_tuser == ACTION_PULL) begin
            if (!ready_q || rp_q >= len_q) begin
              stat_d = STATUS_NOT_READY;
              state_d = ST_OUT;
            end else begin
              state_d = ST_PULL;
            end
          end else begin
            if (len_q >= LW'(BLOCK_MAX)) begin
              over_d = 1'b1;
              stat_d = STATUS_TOO_LONG;
              state_d = ST_OUT;
            end else begin
              cs_we = 1'b1;
              byte_d = s_axis_tdata[7:0];
              len_new = len_q + LW'(1);
              len_d = len_new;
              state_d = ST_CNT_RD;
            end
            if (s_axis_tlast) begin
              if (over_q || len_q >= LW'(BLOCK_MAX)) begin
                stat_d = STATUS_TOO_LONG;
              end else if (32'(s_axis_tdata[19:8]) >= 32'(len_new)) begin
                stat_d = STATUS_BAD_INDEX;
              end
              pos_d = pi;
            end
          end
        end else if (s_axis_tvalid && ready_q && s_axis_tuser == ACTION_LOAD) begin
          // A load drops the finished block: sweep the histogram, then take it.
          ready_d = 1'b0; len_d = '0; rp_d = '0; over_d = 1'b0; sym_d = '0;
          state_d = ST_CLEAR;
        end
      end
      ST_CNT_RD: state_d = ST_CNT_WR;
      ST_CNT_WR: begin
        ct_we = 1'b1; ct_wa = byte_q; ct_wd = ct_rd + LW'(1);
        if (!last_q) state_d = ST_OUT;
        else if (stat_q != STATUS_OK) begin
          state_d = ST_OUT;
        end else begin
          sym_d = '0; run_d = '0; pfx_ph_d = 1'b0; state_d = ST_PFX;
        end
      end
      ST_PFX: begin
        // Replace each count with its running start, reading then writing each symbol.
        ct_ra = sym_q[7:0];
        pfx_ph_d = ~pfx_ph_q;
        if (pfx_ph_q) begin
          ct_we = 1'b1; ct_wd = run_q;
          run_d = run_q + ct_rd;
          sym_d = sym_q + 9'd1;
          if (sym_q == 9'd255) begin
            idx_d = '0; state_d = ST_RNK_RD;
          end
        end
      end
      ST_RNK_RD: begin
        // Read coded byte at idx; next cycle read its start.
        if (idx_q == len_q) begin
          idx_d = len_q; state_d = ST_WLK_RD;
        end else begin
          state_d = ST_RNK_WR;
        end
      end
      ST_RNK_WR: begin
        ct_ra = cs_rd;
        byte_d = cs_rd;
        pfx_ph_d = ~pfx_ph_q;
        if (pfx_ph_q) begin
          ct_ra = byte_q;
          rk_we = 1'b1; rk_wd = ct_rd[AW-1:0];
          ct_we = 1'b1; ct_wa = byte_q; ct_wd = ct_rd + LW'(1);
          idx_d = idx_q + LW'(1);
          state_d = ST_RNK_RD;
        end
      end
      ST_WLK_RD: begin
        cs_ra = pos_q;
        if (idx_q == '0) begin
          ready_d = 1'b1; rp_d = '0; state_d = ST_OUT;
        end else begin
          state_d = ST_WLK_WR;
        end
      end
      ST_WLK_WR: begin
        rs_we = 1'b1; rs_wa = AW'(idx_q - LW'(1)); rs_wd = cs_rd;
        pos_d = rk_rd;
        idx_d = idx_q - LW'(1);
        state_d = ST_WLK_RD;
      end
      ST_PULL: begin
        byte_d = rs_rd; obv_d = 1'b1; ovalid_d = 1'b1;
        if (rp_q + LW'(1) == len_q) begin
          olast_d = 1'b1; ready_d = 1'b0; len_d = '0; rp_d = '0; sym_d = '0;
        end else begin
          rp_d = rp_q + LW'(1);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          if (olast_q || (last_q && stat_q != STATUS_OK && !obv_q)) begin
            len_d = '0; rp_d = '0; over_d = 1'b0; ready_d = 1'b0; sym_d = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; len_q <= '0; rp_q <= '0; idx_q <= '0; pos_q <= '0;
      sym_q <= '0; run_q <= '0; ready_q <= 1'b0; over_q <= 1'b0; last_q <= 1'b0;
      byte_q <= '0; stat_q <= STATUS_OK; ovalid_q <= 1'b0; olast_q <= 1'b0;
      obv_q <= 1'b0; pfx_ph_q <= 1'b0;
    end else begin
      state_q <= state_d; len_q <= len_d; rp_q <= rp_d; idx_q <= idx_d; pos_q <= pos_d;
      sym_q <= sym_d; run_q <= run_d; ready_q <= ready_d; over_q <= over_d;
      last_q <= last_d; byte_q <= byte_d; stat_q <= stat_d; ovalid_q <= ovalid_d;
      olast_q <= olast_d; obv_q <= obv_d; pfx_ph_q <= pfx_ph_d;
    end
  end

  // Result transaction.
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {5'd0, stat_q, ovalid_q, (obv_q ? byte_q : 8'd0)};
  assign m_axis_tlast = olast_q;
endmodule

// ===== dv/ibwt_checker.sv =====
// Checker for inverse_bwt_block: watches both stream channels, predicts every result.
// Depends on ibwt_pkg for the action and status codes.
module ibwt_checker
  import ibwt_pkg::*;
#(
  parameter int unsigned BLOCK_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       out_valid;
    logic       out_last;
    logic [1:0] status;
  } restored_result_t;

  restored_result_t expected_q[$];

  // Shadow of the block state.
  logic [7:0]  coded_mem[BLOCK_MAX];
  logic [11:0] rank_mem[BLOCK_MAX];
  logic [7:0]  restored_mem[BLOCK_MAX];
  int unsigned hist[SYMBOLS];
  int unsigned held_len;
  int unsigned pull_ptr;
  bit          restored_ready;
  bit          overflowed;

  assign pending_o = expected_q.size();

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  task automatic clear_block();
    foreach (hist[i]) hist[i] = 0;
    held_len = 0;
    pull_ptr = 0;
    restored_ready = 0;
    overflowed = 0;
  endtask

  // Histogram to running starts, ranks, then walk the chain backwards.
  task automatic restore_block(input int unsigned row);
    int unsigned run_start[SYMBOLS];
    int unsigned acc;
    int unsigned pos;
    acc = 0;
    pos = row;
    for (int s = 0; s < SYMBOLS; s++) begin
      run_start[s] = acc;
      acc += hist[s];
    end
    for (int unsigned i = 0; i < held_len; i++) begin
      rank_mem[i] = 12'(run_start[coded_mem[i]]);
      run_start[coded_mem[i]]++;
    end
    for (int unsigned k = held_len; k > 0; k--) begin
      if (pos >= BLOCK_MAX) pos = 0;
      restored_mem[k-1] = coded_mem[pos];
      pos = rank_mem[pos];
    end
  endtask

  task automatic predict_item(input logic act, input logic [7:0] b, input logic [11:0] row,
                              input logic lst);
    restored_result_t r;
    r = '0;
    r.status = STATUS_OK;
    if (act == ACTION_LOAD) begin
      if (restored_ready) clear_block();
      if (held_len >= BLOCK_MAX) begin
        overflowed = 1;
        r.status = STATUS_TOO_LONG;
      end else begin
        coded_mem[held_len] = b;
        hist[b]++;
        held_len++;
      end
      if (lst) begin
        if (overflowed) begin
          r.status = STATUS_TOO_LONG;
          clear_block();
        end else if (row >= held_len) begin
          r.status = STATUS_BAD_INDEX;
          clear_block();
        end else begin
          restore_block(row);
          restored_ready = 1;
          pull_ptr = 0;
        end
      end
    end else begin
      if (!restored_ready || pull_ptr >= held_len) begin
        r.status = STATUS_NOT_READY;
      end else begin
        r.byte_out = restored_mem[pull_ptr];
        r.out_valid = 1;
        if (pull_ptr + 1 == held_len) begin
          r.out_last = 1;
          clear_block();
        end else begin
          pull_ptr++;
        end
      end
    end
    expected_q = {expected_q, r};
  endtask

  // Predict on each input transaction, compare on each output transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    restored_result_t exp_r;
    if (!rst_ni) begin
      mismatch_count_o = 0;
      expected_q.delete();
      clear_block();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[19:8], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata[7:0] !== exp_r.byte_out)
            report_mismatch($sformatf("byte_out %h, expected %h",
                                      m_axis_tdata[7:0], exp_r.byte_out));
          if (m_axis_tdata[8] !== exp_r.out_valid)
            report_mismatch($sformatf("out_valid %b, expected %b",
                                      m_axis_tdata[8], exp_r.out_valid));
          if (m_axis_tlast !== exp_r.out_last)
            report_mismatch($sformatf("out_last %b, expected %b",
                                      m_axis_tlast, exp_r.out_last));
          if (m_axis_tdata[10:9] !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tdata[10:9], exp_r.status));
          if (m_axis_tdata[15:11] !== 5'd0)
            report_mismatch($sformatf("pad bits %h not zero", m_axis_tdata[15:11]));
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Top of the inverse_bwt_block testbench: clock, reset, stimulus and verdict.
// Depends on ibwt_pkg, inverse_bwt_block and ibwt_checker.
module tb_top;
  import ibwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_MAX = 4096;
  localparam int unsigned TOTAL_ITEMS = 650;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          mismatch_count;
  int          pending;
  int          items_sent;
  bit          calm_sink;

  inverse_bwt_block #(.BLOCK_MAX(BLOCK_MAX)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  ibwt_checker #(.BLOCK_MAX(BLOCK_MAX)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver stall pattern; calm stretches keep tready high.
  initial begin
    m_axis_tready = 0;
    calm_sink = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(199) == 0) calm_sink <= ~calm_sink;
      if (calm_sink || pick_gap() == 0) m_axis_tready <= 1;
      else m_axis_tready <= 0;
    end
  end

  // Drive one item and hold it until the transaction happens.
  task automatic send_item(input logic act, input logic [7:0] b, input logic [11:0] row,
                           input logic lst, input bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tlast <= lst;
    s_axis_tdata <= {4'd0, row, b};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_with_row(input int unsigned len, input logic [11:0] row,
                               input bit no_gap = 0);
    for (int unsigned i = 0; i + 1 < len; i++)
      send_item(ACTION_LOAD, 8'($urandom_range(255)), 12'($urandom_range(4095)), 1'b0,
                no_gap);
    send_item(ACTION_LOAD, 8'($urandom_range(255)), row, 1'b1, no_gap);
  endtask

  task automatic pull_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(ACTION_PULL, 8'($urandom_range(255)), 12'($urandom_range(4095)),
                1'($urandom_range(1)));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned len;
    int unsigned roll;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = ACTION_LOAD;
    s_axis_tlast = 0;
    items_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: nothing ready, single-byte block, byte extremes.
    send_item(ACTION_PULL, 8'hFF, 12'hFFF, 1'b1);
    send_item(ACTION_LOAD, 8'h00, 12'h000, 1'b1);
    pull_bytes(2);
    send_item(ACTION_LOAD, 8'hFF, 12'hABC, 1'b0);
    send_item(ACTION_LOAD, 8'hAA, 12'h543, 1'b0);
    send_item(ACTION_LOAD, 8'h55, 12'h000, 1'b0);
    send_item(ACTION_LOAD, 8'h00, 12'h003, 1'b1);
    pull_bytes(4);
    // Bad primary index: all ones, and exactly the block length.
    load_with_row(2, 12'hFFF);
    load_with_row(2, 12'd2);
    // A new load drops a partly pulled block.
    load_with_row(3, 12'd0);
    pull_bytes(1);
    load_with_row(2, 12'd1);
    pull_bytes(2);
    // Back-to-back block with the highest row of its length.
    load_with_row(40, 12'd39, 1);
    pull_bytes(3);
    load_with_row(2, 12'd0);
    pull_bytes(2);

    // Hold the sender until every outstanding result has come back.
    drain_results();

    // Random: mostly well-formed blocks with random content, some noise.
    while (items_sent < TOTAL_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(200, 13) : $urandom_range(12, 1);
        if ($urandom_range(9) == 0) load_with_row(len, 12'($urandom_range(4095)));
        else load_with_row(len, 12'($urandom_range(len - 1)));
        roll = $urandom_range(9);
        if (roll < 7) pull_bytes(len);
        else if (roll < 9) pull_bytes($urandom_range(len));
        else pull_bytes(len + $urandom_range(3, 1));
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 12'($urandom_range(4095)),
                  1'($urandom_range(1)));
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) $display("inverse_bwt_block verification clean");
    else $display("inverse_bwt_block verification failed");
    $finish;
  end

  // Overall run limit.
  initial begin
    #10ms;
    $display("inverse_bwt_block verification failed");
    $finish;
  end
endmodule
